### hw/rtl/stip_pkg.sv
// ----------------------------------------------------------------------------
// stip_pkg
// Shared types and constants of the string-to-integer parser.
// ----------------------------------------------------------------------------
package stip_pkg;

   // configuration register indexes
   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth  = 5;
   localparam logic [CsrIndexWidth-1:0] CSR_BASE        = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SIGNED_MODE = 1'd1;

   localparam logic [4:0] BASE_RESET   = 5'd10;
   localparam logic [4:0] BASE_DECIMAL = 5'd10;
   localparam logic [4:0] BASE_OCTAL   = 5'd8;
   localparam logic [4:0] BASE_HEX     = 5'd16;
   localparam logic [4:0] DIGIT_NONE   = 5'd16;

   // character codes
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_VT      = 8'h0B;
   localparam logic [7:0] CHAR_FF      = 8'h0C;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;

   // queue between front and back
   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   // one classified character
   typedef struct packed {
      logic       start;
      logic [4:0] digit;
      logic       is_space;
      logic       is_plus;
      logic       is_minus;
      logic       is_zero;
      logic       is_x;
      logic       is_nul;
      logic [4:0] base;
      logic       signed_mode;
   } entry_type;

endpackage

### hw/rtl/stip_front.sv
// ----------------------------------------------------------------------------
// stip_front
// Holds the configuration registers, accepts characters and classifies them.
// ----------------------------------------------------------------------------
module stip_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [stip_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [stip_pkg::CsrDataWidth-1:0]   csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_ch,
   input  logic                                req_start_req,
   input  logic                                queue_full,
   output logic                                push,
   output stip_pkg::entry_type                 push_entry
);
   import stip_pkg::*;

   logic [4:0] base_ff;
   logic       signed_mode_ff;
   logic [4:0] digit;
   logic [4:0] base_clamped;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff        <= BASE_RESET;
         signed_mode_ff <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BASE:        base_ff        <= csr_wr_data;
            CSR_SIGNED_MODE: signed_mode_ff <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (req_ch >= CHAR_ZERO && req_ch <= CHAR_NINE) begin
         digit = 5'(req_ch - CHAR_ZERO);
      end else if (req_ch >= CHAR_LOWER_A && req_ch <= CHAR_LOWER_F) begin
         digit = 5'(req_ch - CHAR_LOWER_A) + BASE_DECIMAL;
      end else if (req_ch >= CHAR_UPPER_A && req_ch <= CHAR_UPPER_F) begin
         digit = 5'(req_ch - CHAR_UPPER_A) + BASE_DECIMAL;
      end else begin
         digit = DIGIT_NONE;
      end
   end

   // bases above sixteen act as sixteen
   assign base_clamped = (base_ff > BASE_HEX) ? BASE_HEX : base_ff;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_entry.start       = req_start_req;
      push_entry.digit       = digit;
      push_entry.is_space    = (req_ch == CHAR_SPACE) || (req_ch == CHAR_TAB) ||
                               (req_ch == CHAR_LF) || (req_ch == CHAR_CR) ||
                               (req_ch == CHAR_FF) || (req_ch == CHAR_VT);
      push_entry.is_plus     = (req_ch == CHAR_PLUS);
      push_entry.is_minus    = (req_ch == CHAR_MINUS);
      push_entry.is_zero     = (req_ch == CHAR_ZERO);
      push_entry.is_x        = (req_ch == CHAR_LOWER_X) || (req_ch == CHAR_UPPER_X);
      push_entry.is_nul      = (req_ch == CHAR_NUL);
      push_entry.base        = base_clamped;
      push_entry.signed_mode = signed_mode_ff;
   end

endmodule

### hw/rtl/stip_queue.sv
// ----------------------------------------------------------------------------
// stip_queue
// Short first-in first-out queue of classified characters.
// ----------------------------------------------------------------------------
module stip_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  stip_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                pop_valid,
   output stip_pkg::entry_type pop_entry
);
   import stip_pkg::*;

   entry_type                  mem_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]   wr_ptr_ff;
   logic [QueuePtrWidth-1:0]   rd_ptr_ff;
   logic [QueueCountWidth-1:0] count_ff;
   logic [QueueCountWidth-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QueueCountWidth'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QueueCountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QueuePtrWidth'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QueuePtrWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full      = (count_ff == QueueCountWidth'(QueueDepth));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = mem_ff[rd_ptr_ff];

endmodule

### hw/rtl/stip_back.sv
// ----------------------------------------------------------------------------
// stip_back
// Parse engine: walks whitespace, sign, prefix and digits, and registers
// the result of each finished string.
// ----------------------------------------------------------------------------
module stip_back #(
   parameter int VALUE_WIDTH = 64,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   entry_valid,
   input  stip_pkg::entry_type    entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VALUE_WIDTH-1:0] rsp_value,
   output logic [COUNT_WIDTH-1:0] rsp_consumed,
   output logic                   rsp_hit_end
);
   import stip_pkg::*;

   typedef enum logic [2:0] {
      PH_DONE,
      PH_SPACE,
      PH_PREFIX,
      PH_ZERO,
      PH_DIGITS
   } phase_type;

   phase_type              phase_ff,  phase_in;
   logic [VALUE_WIDTH-1:0] acc_ff,    acc_in;
   logic                   neg_ff,    neg_in;
   logic [4:0]             wbase_ff,  wbase_in;
   logic [COUNT_WIDTH-1:0] cnt_ff,    cnt_in;
   logic                   rsp_valid_ff;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;
   logic [COUNT_WIDTH-1:0] rsp_consumed_ff;
   logic                   rsp_hit_end_ff;

   logic                   cont;
   logic                   bump;
   logic                   fin;
   logic                   at_end;
   logic [VALUE_WIDTH-1:0] acc_mul;
   logic                   out_free;

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      wbase_in = wbase_ff;
      cnt_in   = cnt_ff;
      cont     = 1'b1;
      bump     = 1'b0;
      fin      = 1'b0;
      at_end   = 1'b0;
      acc_mul  = '0;

      if (entry.start) begin
         acc_in   = '0;
         neg_in   = 1'b0;
         cnt_in   = '0;
         wbase_in = entry.base;
         phase_in = PH_SPACE;
      end

      if (phase_in == PH_DONE) begin
         cont = 1'b0;
      end

      if (cont && phase_in == PH_SPACE) begin
         if (entry.is_space) begin
            bump = 1'b1;
            cont = 1'b0;
         end else begin
            phase_in = PH_PREFIX;
            if (entry.signed_mode && (entry.is_plus || entry.is_minus)) begin
               neg_in = entry.is_minus;
               bump   = 1'b1;
               cont   = 1'b0;
            end
         end
      end

      if (cont && phase_in == PH_PREFIX) begin
         phase_in = PH_DIGITS;
         if (wbase_in == '0) begin
            if (entry.is_zero) begin
               bump     = 1'b1;
               phase_in = PH_ZERO;
               cont     = 1'b0;
            end else begin
               wbase_in = BASE_DECIMAL;
            end
         end
      end

      if (cont && phase_in == PH_ZERO) begin
         phase_in = PH_DIGITS;
         if (entry.is_x) begin
            wbase_in = BASE_HEX;
            bump     = 1'b1;
            cont     = 1'b0;
         end else begin
            wbase_in = BASE_OCTAL;
         end
      end

      // shift-add multiply by the 5-bit base
      for (int i = 0; i < 5; i++) begin
         if (wbase_in[i]) begin
            acc_mul = acc_mul + (acc_in << i);
         end
      end

      if (cont) begin
         if (entry.is_nul) begin
            fin    = 1'b1;
            at_end = 1'b1;
         end else if (entry.digit >= wbase_in) begin
            fin = 1'b1;
         end else begin
            acc_in = acc_mul + {{(VALUE_WIDTH-5){1'b0}}, entry.digit};
            bump   = 1'b1;
         end
      end

      if (fin) begin
         phase_in = PH_DONE;
      end

      if (bump && cnt_in != {COUNT_WIDTH{1'b1}}) begin
         cnt_in = cnt_in + COUNT_WIDTH'(1);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   // hold a finishing character until the result slot is free
   assign pop = entry_valid && (!fin || out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            neg_ff   <= neg_in;
            wbase_ff <= wbase_in;
            cnt_ff   <= cnt_in;
         end
         if (pop && fin) begin
            rsp_valid_ff    <= 1'b1;
            rsp_value_ff    <= neg_in ? (VALUE_WIDTH'(0) - acc_in) : acc_in;
            rsp_consumed_ff <= cnt_in;
            rsp_hit_end_ff  <= at_end;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_consumed = rsp_consumed_ff;
   assign rsp_hit_end  = rsp_hit_end_ff;

endmodule

### hw/rtl/string_to_integer_parser.sv
// ----------------------------------------------------------------------------
// string_to_integer_parser
// Streaming strtol/strtoul-style parser, one character per transaction.
// ----------------------------------------------------------------------------
// Request channel (req_): one character per transaction, req_start_req marks
// the first character of a new string. Response channel (rsp_): one result
// (value, consumed count, hit_end) per string, when parsing stops at a NUL
// or at the first invalid character. Characters after the stop are dropped
// until the next start.
// Configuration (csr_): base (index 0, 0 = auto-detect) and signed_mode
// (index 1); write only while the block is idle. Base is sampled per string.
// Throughput: one character per cycle while not stalled. The front
// classifies and queues a character in the cycle it is accepted; the back
// consumes one queue entry per cycle with one shift-add accumulator update.
// The result of a string is registered in the back's output register when
// its stopping character is popped from the queue.
// Stall: a stalled result holds in the output register; the back keeps
// working until the next string stops, then the four-entry queue fills and
// req_stall rises.
// Reset: clears the queue, drops any result and any parse in progress, and
// restores base 10 and signed mode.
// ----------------------------------------------------------------------------
module string_to_integer_parser #(
   parameter int VALUE_WIDTH = 64,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [stip_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [stip_pkg::CsrDataWidth-1:0]  csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_ch,
   input  logic                               req_start_req,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [VALUE_WIDTH-1:0]             rsp_value,
   output logic [COUNT_WIDTH-1:0]             rsp_consumed,
   output logic                               rsp_hit_end
);
   import stip_pkg::*;

   logic      queue_full;
   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      pop_valid;
   entry_type pop_entry;

   stip_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ch        (req_ch),
      .req_start_req (req_start_req),
      .queue_full    (queue_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   stip_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   stip_back #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .entry_valid  (pop_valid),
      .entry        (pop_entry),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_value    (rsp_value),
      .rsp_consumed (rsp_consumed),
      .rsp_hit_end  (rsp_hit_end)
   );

endmodule

### hw/rtl/stip_checker.sv
// ----------------------------------------------------------------------------
// stip_checker
// Port-level checks of the parser, bound to the top level.
// ----------------------------------------------------------------------------
module stip_checker #(
   parameter int VALUE_WIDTH = 64,
   parameter int COUNT_WIDTH = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [VALUE_WIDTH-1:0] rsp_value,
   input logic [COUNT_WIDTH-1:0] rsp_consumed,
   input logic                   rsp_hit_end
);

   // a stalled result stays and holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) &&
         $stable(rsp_consumed) && $stable(rsp_hit_end))
      else $error("stalled result changed");

   // reset empties the queue and the output register
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state left after reset");

   // the queue only fills by accepting a character
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid))
      else $error("request stall rose without a transaction");

endmodule

bind string_to_integer_parser stip_checker #(
   .VALUE_WIDTH (VALUE_WIDTH),
   .COUNT_WIDTH (COUNT_WIDTH)
) u_stip_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_value    (rsp_value),
   .rsp_consumed (rsp_consumed),
   .rsp_hit_end  (rsp_hit_end)
);
